>>> rtl/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CountW = 61;
  localparam logic [7:0] PadMark = 8'h80;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_ROUNDS,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_byte;
    logic pad_fill;
    logic init_round;
    logic do_round;
    logic fold;
    logic reinit;
  } dp_cmd_t;

  typedef struct packed {
    logic block_full;
    logic pad_extra;
  } dp_status_t;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    round_k = k[i];
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    init_h = h[i];
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_if.sv
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, message_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, message_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

>>> rtl/sha256_stream_hasher_unit.sv
`default_nettype none
// Channel  | Dir | Payload
// in       | in  | message_byte, has_byte, end_of_message
// out      | out | digest_word, word_index, last_word
// A byte item is taken while collecting; the 64th byte of a block starts the
// 64 rounds of the single round unit, then the fold, taking no input meanwhile.
// A final item adds one or two padding blocks, each hashed, then eight words.
// Reset is synchronous, active low, and loads the initial hash values.
// A stalled output holds the current digest word until it is taken.
module sha256_stream_hasher_unit (
  input wire          clk,
  input wire          rst_n,
  sha256_in_if.sink   in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [5:0] round_idx;
  logic [2:0] word_sel;
  word_t      digest;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .has_byte(in_ch.has_byte), .end_of_message(in_ch.end_of_message),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd), .round_idx(round_idx), .word_sel(word_sel)
  );

  sha256_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .byte_in(in_ch.message_byte),
    .round_idx(round_idx), .word_sel(word_sel), .status(status), .digest_out(digest)
  );

  assign out_ch.digest_word = digest;
  assign out_ch.word_index = word_sel;
  assign out_ch.last_word = (word_sel == 3'd7);
endmodule
`default_nettype wire

>>> rtl/sha256_datapath.sv
`default_nettype none
module sha256_datapath (
  input  wire                     clk,
  input  wire                     rst_n,
  input  sha256_pkg::dp_cmd_t     cmd,
  input  wire [7:0]               byte_in,
  input  wire [5:0]               round_idx,
  input  wire [2:0]               word_sel,
  output sha256_pkg::dp_status_t  status,
  output sha256_pkg::word_t       digest_out
);
  import sha256_pkg::*;

  word_t             blk_r [16];
  word_t             pad_blk [16];
  logic [CountW-1:0] count_r, count_nxt;
  word_t             h_r [8];
  word_t             v_r [8];
  word_t             w_r [16];
  logic [5:0]        pos;
  logic [63:0]       bits;
  word_t             w_cur, s0w, s1w, s1, ch, t1, s0, mj, t2;

  assign pos = count_r[5:0];
  assign bits = {count_r, 3'b000};
  assign status.block_full = (pos == 6'd63);
  assign status.pad_extra = (pos > 6'd55);
  assign digest_out = h_r[word_sel];

  always_comb begin
    s0w = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1w = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    if (round_idx < 6'd16) begin
      w_cur = blk_r[round_idx[3:0]];
    end else begin
      w_cur = w_r[0] + s0w + w_r[9] + s1w;
    end
    s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + round_k(round_idx) + w_cur;
    s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
    count_nxt = count_r + CountW'(1);
  end

  always_comb begin
    logic [5:0] p;
    logic [7:0] pad_byte;
    word_t      tail;
    word_t      pad_word;
    for (int i = 0; i < 16; i++) begin
      tail = (i == 15) ? bits[31:0] : bits[63:32];
      pad_word = blk_r[i];
      for (int j = 0; j < 4; j++) begin
        p = 6'(4 * i + j);
        pad_byte = blk_r[i][8 * (3 - j) +: 8];
        if (round_idx[0]) begin
          pad_byte = (i >= 14) ? tail[8 * (3 - j) +: 8] : 8'h00;
        end else if (p == pos) begin
          pad_byte = PadMark;
        end else if (p > pos) begin
          pad_byte = (i >= 14 && !status.pad_extra) ? tail[8 * (3 - j) +: 8] : 8'h00;
        end
        pad_word[8 * (3 - j) +: 8] = pad_byte;
      end
      pad_blk[i] = pad_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= init_h(3'(i));
      end
    end else begin
      if (cmd.load_byte) begin
        count_r <= count_nxt;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
      if (cmd.reinit) begin
        count_r <= '0;
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= init_h(3'(i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      blk_r[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= byte_in;
    end
    if (cmd.pad_fill) begin
      for (int i = 0; i < 16; i++) begin
        blk_r[i] <= pad_blk[i];
      end
    end
    if (cmd.init_round) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end
    if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[15] <= w_cur;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end
endmodule
`default_nettype wire

>>> rtl/sha256_ctrl.sv
`default_nettype none
module sha256_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     has_byte,
  input  wire                     end_of_message,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  sha256_pkg::dp_status_t  status,
  output sha256_pkg::dp_cmd_t     cmd,
  output logic [5:0]              round_idx,
  output logic [2:0]              word_sel
);
  import sha256_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  wsel_r, wsel_nxt;
  logic        final_r, final_nxt;
  logic        second_r, second_nxt;

  assign round_idx = (state_r == ST_PAD) ? {5'd0, second_r} : rnd_r;
  assign word_sel = wsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_COLLECT;
      rnd_r    <= '0;
      wsel_r   <= '0;
      final_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      wsel_r   <= wsel_nxt;
      final_r  <= final_nxt;
      second_r <= second_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    wsel_nxt   = wsel_r;
    final_nxt  = final_r;
    second_nxt = second_r;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_valid) begin
          final_nxt = end_of_message;
          second_nxt = 1'b0;
          if (has_byte) begin
            cmd.load_byte = 1'b1;
          end
          if (has_byte && status.block_full) begin
            cmd.init_round = 1'b1;
            rnd_nxt = '0;
            state_nxt = ST_ROUNDS;
          end else if (end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.pad_fill = 1'b1;
        cmd.init_round = 1'b1;
        rnd_nxt = '0;
        if (!second_r && status.pad_extra) begin
          second_nxt = 1'b1;
        end else begin
          final_nxt = 1'b0;
          second_nxt = 1'b1;
        end
        state_nxt = ST_ROUNDS;
      end
      ST_ROUNDS: begin
        cmd.do_round = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (final_r) begin
          state_nxt = ST_PAD;
        end else if (second_r) begin
          wsel_nxt = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          wsel_nxt = wsel_r + 3'd1;
          if (wsel_r == 3'd7) begin
            cmd.reinit = 1'b1;
            second_nxt = 1'b0;
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

`ifndef SYNTH
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_COLLECT) |-> !in_ready) else $error("input taken while busy");
  a_rounds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD) |-> ($past(rnd_r) == 6'd63)) else $error("fold before 64 rounds");
  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && wsel_r != 3'd7) |=> (wsel_r == $past(wsel_r) + 3'd1))
    else $error("digest word order broken");
`endif
endmodule
`default_nettype wire
